// ===== hw/rtl/aes_sbsr_pkg.sv =====
// types, constants and byte functions for the aes subbytes / shiftrows unit
`timescale 1ns / 1ps

package aes_sbsr_pkg;

    // operation select carried in tuser
    typedef enum logic [1:0] {
        OP_SUB_BYTES      = 2'd0,
        OP_INV_SUB_BYTES  = 2'd1,
        OP_SHIFT_ROWS     = 2'd2,
        OP_INV_SHIFT_ROWS = 2'd3
    } opcode_t;

    localparam int unsigned NUM_BYTES  = 16;
    localparam int unsigned STATE_BITS = 128;
    localparam int unsigned HALF_BITS  = 64;

    localparam logic [7:0] AFFINE_CONST     = 8'h63;
    localparam logic [7:0] INV_AFFINE_CONST = 8'h05;
    localparam logic [8:0] GF_POLY          = 9'h11b;

    // state as sixteen bytes, index k is row k%4, column k/4
    typedef logic [NUM_BYTES-1:0][7:0] state_t;

    // lookup table of 256 bytes
    typedef logic [7:0] byte_tbl_t [256];

    // rotate a byte left by a constant amount
    function automatic logic [7:0] rotl8(logic [7:0] v, int unsigned n);
        logic [15:0] tmp;
        tmp = {v, v} << (n & 7);
        return tmp[15:8];
    endfunction

    // forward affine transform of the s-box
    function automatic logic [7:0] affine_fwd(logic [7:0] a);
        return a ^ rotl8(a, 1) ^ rotl8(a, 2) ^ rotl8(a, 3) ^ rotl8(a, 4) ^ AFFINE_CONST;
    endfunction

    // inverse affine transform, applied before the field inverse
    function automatic logic [7:0] affine_inv(logic [7:0] y);
        return rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6) ^ INV_AFFINE_CONST;
    endfunction

    // multiply in gf(2^8), used only to build the table at elaboration
    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [8:0] acc;
        logic [8:0] x;
        acc = '0;
        x   = {1'b0, a};
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = x << 1;
            if (x[8]) begin
                x = x ^ GF_POLY;
            end
        end
        return acc[7:0];
    endfunction

    // a^254 is the inverse of a, and zero for zero
    function automatic logic [7:0] gf_inv(logic [7:0] a);
        logic [7:0] res;
        logic [7:0] base;
        logic [7:0] e;
        res  = 8'd1;
        base = a;
        e    = 8'd254;
        for (int i = 0; i < 8; i++) begin
            if (e[i]) begin
                res = gf_mul(res, base);
            end
            base = gf_mul(base, base);
        end
        return res;
    endfunction

    function automatic byte_tbl_t gf_inv_table();
        byte_tbl_t tbl;
        for (int i = 0; i < 256; i++) begin
            tbl[i] = gf_inv(8'(i));
        end
        return tbl;
    endfunction

    // multiplicative inverse table, built at elaboration
    localparam byte_tbl_t GF_INV_TBL = gf_inv_table();

    // source byte index for shiftrows (inv = 0) or invshiftrows (inv = 1)
    function automatic int unsigned shift_src(int unsigned dst, bit inv);
        int unsigned row;
        int unsigned col;
        int unsigned src_col;
        row = dst & 3;
        col = dst >> 2;
        if (inv) begin
            src_col = (col + 4 - row) & 3;
        end else begin
            src_col = (col + row) & 3;
        end
        return (src_col << 2) + row;
    endfunction

endpackage

// ===== hw/rtl/aes_subbytes_shiftrows_unit.sv =====
// aes subbytes / invsubbytes / shiftrows / invshiftrows three-stage datapath
`timescale 1ns / 1ps
// path: an accepted beat moves through d1_reg, d2_reg and d3_reg onto m_tdata
// throughput: one beat per cycle; a stalled pipe takes beats until it is full
// stages: byte select or inverse affine, field inverse table, forward affine
// reset: synchronous active-low aresetn clears the stage valid bits only
// a stall on m_tready holds full stages with no bubble after them; empty ones fill

module aes_subbytes_shiftrows_unit
    import aes_sbsr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // input beat
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] state_hi, [127:64] state_lo
    input  logic [1:0]   s_tuser,   // [1:0] opcode
    // result beat
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // [63:0] result_hi, [127:64] result_lo
);

    // stage registers
    logic    v1_reg, v2_reg, v3_reg;
    logic    v1_next, v2_next, v3_next;
    opcode_t op1_reg, op2_reg;
    state_t  d1_reg, d2_reg, d3_reg;
    state_t  d1_next, d2_next, d3_next;

    logic    en1, en2, en3;
    state_t  in_bytes;
    opcode_t in_op;

    // advance enables, back to front
    assign en3 = !v3_reg || m_tready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_tready = en1;
    assign m_tvalid = v3_reg;
    assign in_op    = opcode_t'(s_tuser);

    // unpack input, byte 0 at the top of state_hi
    for (genvar k = 0; k < NUM_BYTES; k++) begin : g_unpack
        if (k < 8) begin : g_hi
            assign in_bytes[k] = s_tdata[HALF_BITS-1-8*k -: 8];
        end else begin : g_lo
            assign in_bytes[k] = s_tdata[STATE_BITS-1-8*(k-8) -: 8];
        end
    end

    // stage 1: row rotation, inverse affine, or pass-through for subbytes
    for (genvar k = 0; k < NUM_BYTES; k++) begin : g_stage1
        always_comb begin
            case (in_op)
                OP_SUB_BYTES:      d1_next[k] = in_bytes[k];
                OP_INV_SUB_BYTES:  d1_next[k] = affine_inv(in_bytes[k]);
                OP_SHIFT_ROWS:     d1_next[k] = in_bytes[4'(shift_src(k, 1'b0))];
                OP_INV_SHIFT_ROWS: d1_next[k] = in_bytes[4'(shift_src(k, 1'b1))];
                default:           d1_next[k] = in_bytes[k];
            endcase
        end
    end

    // stage 2: field inverse for the s-box operations
    for (genvar k = 0; k < NUM_BYTES; k++) begin : g_stage2
        always_comb begin
            case (op1_reg)
                OP_SUB_BYTES,
                OP_INV_SUB_BYTES: d2_next[k] = GF_INV_TBL[d1_reg[k]];
                default:          d2_next[k] = d1_reg[k];
            endcase
        end
    end

    // stage 3: forward affine for subbytes
    for (genvar k = 0; k < NUM_BYTES; k++) begin : g_stage3
        always_comb begin
            case (op2_reg)
                OP_SUB_BYTES: d3_next[k] = affine_fwd(d2_reg[k]);
                default:      d3_next[k] = d2_reg[k];
            endcase
        end
    end

    // valid bits move with the data
    always_comb begin
        v1_next = en1 ? s_tvalid : v1_reg;
        v2_next = en2 ? v1_reg   : v2_reg;
        v3_next = en3 ? v2_reg   : v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // payload registers, loaded when their stage advances
    always_ff @(posedge aclk) begin
        if (en1) begin
            d1_reg  <= d1_next;
            op1_reg <= in_op;
        end
        if (en2) begin
            d2_reg  <= d2_next;
            op2_reg <= op1_reg;
        end
        if (en3) begin
            d3_reg  <= d3_next;
        end
    end

    // pack result, byte 0 at the top of result_hi
    for (genvar k = 0; k < NUM_BYTES; k++) begin : g_pack
        if (k < 8) begin : g_hi
            assign m_tdata[HALF_BITS-1-8*k -: 8] = d3_reg[k];
        end else begin : g_lo
            assign m_tdata[STATE_BITS-1-8*(k-8) -: 8] = d3_reg[k];
        end
    end

`ifndef NO_ASSERTIONS
    // an empty first stage always takes a beat
    a_empty_takes: assert property (@(posedge aclk) disable iff (!aresetn)
        !v1_reg |-> s_tready)
        else $error("first stage empty but input not ready");

    // a full, stalled pipe must not take another beat
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && v3_reg && !m_tready) |-> !s_tready)
        else $error("beat taken into a full stalled pipe");

    // an item in stage 2 moves to the output stage when it is free
    a_stage2_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && (!v3_reg || m_tready)) |=> v3_reg)
        else $error("stage 2 item lost on advance");

    // nothing valid right after reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule

// ===== test/tb.sv =====
// self-checking testbench for the aes subbytes / shiftrows unit
`timescale 1ns / 1ps

module tb;
    import aes_sbsr_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_BEATS  = 1500;
    localparam int SEGMENT_BEATS = 100;
    localparam int QUIET_FROM    = 1300;
    localparam int DRAIN_CYCLES  = 10;
    localparam int STALL_LIMIT   = 2000;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } aes_state_t;

    // one directed beat; exp is only used when known is set
    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        opcode_t     op;
        bit          known;
        logic [63:0] exp_hi;
        logic [63:0] exp_lo;
    } dir_row_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;

    // sideband that travels with the beat on the input side
    bit           beat_known = 1'b0;
    aes_state_t   beat_fixed = '0;

    logic [7:0]   fwd_sbox [256];
    logic [7:0]   inv_sbox [256];
    aes_state_t   pending_states [$];
    bit           idle_on = 1'b0;
    int           error_count = 0;
    int           beats_in = 0;
    int           beats_out = 0;
    int           op_count [4] = '{0, 0, 0, 0};
    int           quiet_cycles = 0;
    dir_row_t     dir_rows [18];

    aes_subbytes_shiftrows_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    // multiply two field elements with repeated doubling
    function automatic logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] prod;
        logic [7:0] cur;
        prod = 8'h00;
        cur  = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                prod ^= cur;
            end
            cur = cur[7] ? ((cur << 1) ^ 8'h1b) : (cur << 1);
        end
        return prod;
    endfunction

    // fill both s-box tables: brute-force inverse, bitwise affine map
    task automatic build_sbox_tables();
        logic [7:0] inv;
        logic [7:0] out;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++) begin
                if (x != 0 && field_mul(8'(x), 8'(y)) == 8'h01) begin
                    inv = 8'(y);
                end
            end
            for (int i = 0; i < 8; i++) begin
                out[i] = inv[i] ^ inv[(i + 4) % 8] ^ inv[(i + 5) % 8]
                         ^ inv[(i + 6) % 8] ^ inv[(i + 7) % 8] ^ AFFINE_CONST[i];
            end
            fwd_sbox[x]   = out;
            inv_sbox[out] = 8'(x);
        end
    endtask

    // expected output state for one input beat
    function automatic aes_state_t transform_state(logic [63:0] hi, logic [63:0] lo,
                                                   opcode_t op);
        logic [7:0] src [16];
        logic [7:0] dst [16];
        aes_state_t res;
        int         row;
        int         col;
        for (int k = 0; k < 8; k++) begin
            src[k]     = hi[63 - 8 * k -: 8];
            src[k + 8] = lo[63 - 8 * k -: 8];
        end
        for (int k = 0; k < 16; k++) begin
            row = k % 4;
            col = k / 4;
            case (op)
                OP_SUB_BYTES:      dst[k] = fwd_sbox[src[k]];
                OP_INV_SUB_BYTES:  dst[k] = inv_sbox[src[k]];
                OP_SHIFT_ROWS:     dst[k] = src[4 * ((col + row) % 4) + row];
                default:           dst[k] = src[4 * ((col + 4 - row) % 4) + row];
            endcase
        end
        for (int k = 0; k < 8; k++) begin
            res.hi[63 - 8 * k -: 8] = dst[k];
            res.lo[63 - 8 * k -: 8] = dst[k + 8];
        end
        return res;
    endfunction

    // random word, sometimes built from corner bytes
    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        logic [7:0]  corner [4] = '{8'h00, 8'hff, 8'h63, 8'h52};
        w = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0) begin
            for (int k = 0; k < 8; k++) begin
                if ($urandom_range(0, 1) == 1) begin
                    w[8 * k +: 8] = corner[$urandom_range(0, 3)];
                end
            end
        end
        return w;
    endfunction

    // drive one input beat and wait for it to be taken
    task automatic send_state(logic [63:0] hi, logic [63:0] lo, opcode_t op,
                              bit known, aes_state_t fixed);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {lo, hi};
        s_tuser    <= op;
        beat_known <= known;
        beat_fixed <= fixed;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // result side backpressure in bursts
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 13);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // scoreboard: pop on result beats, predict on input beats
    always @(posedge aclk) begin
        aes_state_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                beats_out++;
                if (pending_states.size() == 0) begin
                    $error("unexpected result beat: got %h", m_tdata);
                    error_count++;
                end else begin
                    want = pending_states.pop_front();
                    if (m_tdata[63:0] !== want.hi) begin
                        $error("result_hi mismatch: expected %h, got %h",
                               want.hi, m_tdata[63:0]);
                        error_count++;
                    end
                    if (m_tdata[127:64] !== want.lo) begin
                        $error("result_lo mismatch: expected %h, got %h",
                               want.lo, m_tdata[127:64]);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                beats_in++;
                op_count[s_tuser]++;
                if (beat_known) begin
                    pending_states.push_back(beat_fixed);
                end else begin
                    pending_states.push_back(transform_state(s_tdata[63:0], s_tdata[127:64],
                                                             opcode_t'(s_tuser)));
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // main sequence
    initial begin
        aes_state_t fixed;
        opcode_t    op;
        build_sbox_tables();

        // directed beats: corners, zero byte, every operation on a byte ramp
        dir_rows = '{
            '{64'h0, 64'h0, OP_SUB_BYTES, 1'b1,
              64'h6363636363636363, 64'h6363636363636363},
            '{64'hffffffffffffffff, 64'hffffffffffffffff, OP_SUB_BYTES, 1'b1,
              64'h1616161616161616, 64'h1616161616161616},
            '{64'h6363636363636363, 64'h6363636363636363, OP_INV_SUB_BYTES, 1'b1,
              64'h0, 64'h0},
            '{64'h0, 64'h0, OP_INV_SUB_BYTES, 1'b1,
              64'h5252525252525252, 64'h5252525252525252},
            '{64'hffffffffffffffff, 64'hffffffffffffffff, OP_INV_SUB_BYTES, 1'b1,
              64'h7d7d7d7d7d7d7d7d, 64'h7d7d7d7d7d7d7d7d},
            '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, OP_SUB_BYTES, 1'b1,
              64'h637c777bf26b6fc5, 64'h3001672bfed7ab76},
            '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, OP_INV_SUB_BYTES, 1'b1,
              64'h52096ad53036a538, 64'hbf40a39e81f3d7fb},
            '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, OP_SHIFT_ROWS, 1'b1,
              64'h00050a0f04090e03, 64'h080d02070c01060b},
            '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, OP_INV_SHIFT_ROWS, 1'b1,
              64'h000d0a0704010e0b, 64'h0805020f0c090603},
            '{64'hffffffffffffffff, 64'hffffffffffffffff, OP_SHIFT_ROWS, 1'b1,
              64'hffffffffffffffff, 64'hffffffffffffffff},
            '{64'h0, 64'h0, OP_INV_SHIFT_ROWS, 1'b1, 64'h0, 64'h0},
            '{64'h0123456789abcdef, 64'hfedcba9876543210, OP_SUB_BYTES, 1'b0,
              64'h0, 64'h0},
            '{64'h0123456789abcdef, 64'hfedcba9876543210, OP_INV_SUB_BYTES, 1'b0,
              64'h0, 64'h0},
            '{64'h0123456789abcdef, 64'hfedcba9876543210, OP_SHIFT_ROWS, 1'b0,
              64'h0, 64'h0},
            '{64'h0123456789abcdef, 64'hfedcba9876543210, OP_INV_SHIFT_ROWS, 1'b0,
              64'h0, 64'h0},
            '{64'h8000000000000001, 64'h0000000000000080, OP_SHIFT_ROWS, 1'b0,
              64'h0, 64'h0},
            '{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, OP_INV_SHIFT_ROWS, 1'b0,
              64'h0, 64'h0},
            '{64'ha5a5a5a55a5a5a5a, 64'h5a5a5a5aa5a5a5a5, OP_SUB_BYTES, 1'b0,
              64'h0, 64'h0}
        };

        // reset
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            fixed.hi = dir_rows[i].exp_hi;
            fixed.lo = dir_rows[i].exp_lo;
            send_state(dir_rows[i].hi, dir_rows[i].lo, dir_rows[i].op,
                       dir_rows[i].known, fixed);
        end

        // random beats; idling switched per segment, none near the end
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            if (i % SEGMENT_BEATS == 0) begin
                idle_on = (i < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            end
            op = opcode_t'($urandom_range(0, 3));
            send_state(rand_word(), rand_word(), op, 1'b0, '0);
        end
        s_tvalid   <= 1'b0;
        beat_known <= 1'b0;

        // drain
        while (pending_states.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb: %0d beats in, %0d results checked", beats_in, beats_out);
        $display("tb: subbytes %0d, inv subbytes %0d, shiftrows %0d, inv shiftrows %0d",
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        if (error_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
